FILE: src/calendar_run_dispatcher_defines.svh
// Assertion macros shared by the dispatcher RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef CALENDAR_RUN_DISPATCHER_DEFINES_SVH
`define CALENDAR_RUN_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define CRD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/crd_pkg.sv
// Types and constants of the calendar run dispatcher.
// No dependencies; used by crd_ctrl, crd_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

   localparam logic       MODE_TICK = 1'b0;
   localparam logic       MODE_LOAD = 1'b1;

   localparam logic [1:0] CSR_ENABLED   = 2'd0;
   localparam logic [1:0] CSR_START_DAY = 2'd1;
   localparam logic [1:0] CSR_END_DAY   = 2'd2;
   localparam logic [1:0] CSR_RUN_COUNT = 2'd3;

   localparam logic [3:0] DROP_MAX = 4'd15;

   typedef struct packed {
      logic        mode;
      logic [2:0]  entry_index;
      logic [7:0]  zone;
      logic [6:0]  day_mask;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] duration;
      logic        time_ok;
      logic [31:0] today;
      logic [2:0]  weekday;
      logic [8:0]  year_day;
      logic        zone_busy;
   } item_type;

   typedef struct packed {
      logic [7:0]  zone;
      logic [6:0]  day_mask;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] duration;
   } run_entry_type;

   typedef struct packed {
      logic [7:0]  zone;
      logic [15:0] duration;
   } queue_slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_TICK,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_result;
      logic load_write;
      logic tick_start;
      logic walk_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic tick_on;
      logic walk_go;
      logic walk_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: src/crd_ctrl.sv
// Sequencer of the calendar run dispatcher: accepts a word, steps the datapath.
// Depends on crd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crd_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  crd_pkg::status_type status,
   output crd_pkg::cmd_type  cmd
);

   crd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         crd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = crd_pkg::ST_SETUP;
            end
         end
         crd_pkg::ST_SETUP: begin
            cmd.clear_result = 1'b1;
            if (status.is_load) begin
               state_in = crd_pkg::ST_LOAD;
            end else if (status.tick_on) begin
               state_in = crd_pkg::ST_TICK;
            end else begin
               state_in = crd_pkg::ST_DONE;
            end
         end
         crd_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = crd_pkg::ST_DONE;
         end
         crd_pkg::ST_TICK: begin
            cmd.tick_start = 1'b1;
            state_in       = status.walk_go ? crd_pkg::ST_WALK : crd_pkg::ST_DONE;
         end
         crd_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_last) begin
               state_in = crd_pkg::ST_DONE;
            end
         end
         crd_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = crd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/crd_datapath.sv
// Datapath of the calendar run dispatcher: config registers, run table memory,
// dispatch queue, fired marks, minute stamp and result register.
// Depends on crd_pkg and calendar_run_dispatcher_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_run_dispatcher_defines.svh"

module crd_datapath #(
   parameter int MAX_RUNS    = 8,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  crd_pkg::cmd_type    cmd,
   output crd_pkg::status_type status,
   input  crd_pkg::item_type   item,
   input  wire                 csr_we,
   input  wire  [1:0]          csr_index,
   input  wire  [31:0]         csr_wdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic                start_valid,
   output logic [7:0]          start_zone,
   output logic [15:0]         start_duration,
   output logic [3:0]          dropped
);

   localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int CW = $clog2(MAX_RUNS + 1);
   localparam int LW = (CW > 4) ? CW : 4;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int XW = (AW > 3) ? AW + 1 : 4;

   // configuration
   logic        enabled_ff;
   logic [31:0] start_day_ff;
   logic [31:0] end_day_ff;
   logic [3:0]  run_count_ff;

   crd_pkg::item_type      itm_ff;
   crd_pkg::run_entry_type table_mem [MAX_RUNS];
   crd_pkg::run_entry_type rd_ff;
   logic [AW-1:0]          rd_addr;

   crd_pkg::queue_slot_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  pend_ff;
   logic [MAX_RUNS-1:0]     fired_ff;
   logic                    stamp_valid_ff;
   logic [8:0]              stamp_yd_ff;
   logic [4:0]              stamp_hour_ff;
   logic [5:0]              stamp_min_ff;

   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_nx;
   logic [CW-1:0] limit;

   logic        res_sv_ff;
   logic [7:0]  res_sz_ff;
   logic [15:0] res_sd_ff;
   logic [3:0]  drop_ff;

   logic          disp_hit;
   logic [QW-1:0] disp_sel;
   logic          free_hit;
   logic [QW-1:0] free_sel;
   logic          do_disp;
   logic          in_range;
   logic          new_min;
   logic          match;
   logic          idx_ok;
   logic [7:0]    mask8;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         start_day_ff <= '0;
         end_day_ff   <= '1;
         run_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            crd_pkg::CSR_ENABLED:   enabled_ff   <= csr_wdata[0];
            crd_pkg::CSR_START_DAY: start_day_ff <= csr_wdata;
            crd_pkg::CSR_END_DAY:   end_day_ff   <= csr_wdata;
            crd_pkg::CSR_RUN_COUNT: run_count_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         itm_ff <= item;
      end
   end

   assign limit  = (LW'(run_count_ff) > LW'(MAX_RUNS)) ? CW'(MAX_RUNS) : CW'(run_count_ff);
   assign idx_nx = idx_ff + CW'(1);
   assign rd_addr = cmd.tick_start ? '0 : idx_nx[AW-1:0];
   assign idx_ok = XW'(itm_ff.entry_index) < XW'(MAX_RUNS);

   // run table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_write && idx_ok) begin
         table_mem[AW'(itm_ff.entry_index)] <= '{
            zone:     itm_ff.zone,
            day_mask: itm_ff.day_mask,
            hour:     itm_ff.hour,
            minute:   itm_ff.minute,
            duration: itm_ff.duration
         };
      end
      rd_ff <= table_mem[rd_addr];
   end

   always_comb begin
      disp_hit = 1'b0;
      disp_sel = '0;
      free_hit = 1'b0;
      free_sel = '0;
      for (int s = QUEUE_DEPTH - 1; s >= 0; s--) begin
         if (pend_ff[s]) begin
            disp_hit = 1'b1;
            disp_sel = QW'(s);
         end else begin
            free_hit = 1'b1;
            free_sel = QW'(s);
         end
      end
   end

   assign do_disp  = cmd.tick_start && !itm_ff.zone_busy && disp_hit;
   assign in_range = (itm_ff.today >= start_day_ff) && (itm_ff.today <= end_day_ff);
   assign new_min  = !stamp_valid_ff || (stamp_yd_ff != itm_ff.year_day) ||
                     (stamp_hour_ff != itm_ff.hour) || (stamp_min_ff != itm_ff.minute);
   assign mask8    = {1'b0, rd_ff.day_mask};
   assign match    = mask8[itm_ff.weekday] && (rd_ff.hour == itm_ff.hour) &&
                     (rd_ff.minute == itm_ff.minute) && !fired_ff[idx_ff[AW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.tick_start) begin
         idx_ff <= '0;
      end else if (cmd.walk_step) begin
         idx_ff <= idx_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff        <= '0;
         fired_ff       <= '0;
         stamp_valid_ff <= 1'b0;
         stamp_yd_ff    <= '0;
         stamp_hour_ff  <= '0;
         stamp_min_ff   <= '0;
      end else begin
         if (cmd.load_write) begin
            fired_ff <= '0;
         end
         if (do_disp) begin
            pend_ff[disp_sel] <= 1'b0;
         end
         if (cmd.tick_start && new_min) begin
            fired_ff       <= '0;
            stamp_valid_ff <= 1'b1;
            stamp_yd_ff    <= itm_ff.year_day;
            stamp_hour_ff  <= itm_ff.hour;
            stamp_min_ff   <= itm_ff.minute;
         end
         if (cmd.walk_step && match) begin
            fired_ff[idx_ff[AW-1:0]] <= 1'b1;
            if (free_hit) begin
               pend_ff[free_sel] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step && match && free_hit) begin
         slot_ff[free_sel] <= '{zone: rd_ff.zone, duration: rd_ff.duration};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_sv_ff <= 1'b0;
         res_sz_ff <= '0;
         res_sd_ff <= '0;
         drop_ff   <= '0;
      end else begin
         if (cmd.clear_result) begin
            res_sv_ff <= 1'b0;
            res_sz_ff <= '0;
            res_sd_ff <= '0;
            drop_ff   <= '0;
         end
         if (do_disp) begin
            res_sv_ff <= 1'b1;
            res_sz_ff <= slot_ff[disp_sel].zone;
            res_sd_ff <= slot_ff[disp_sel].duration;
         end
         if (cmd.walk_step && match && !free_hit && (drop_ff != crd_pkg::DROP_MAX)) begin
            drop_ff <= drop_ff + 4'd1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (cmd.publish) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         start_valid    <= res_sv_ff;
         start_zone     <= res_sz_ff;
         start_duration <= res_sd_ff;
         dropped        <= drop_ff;
      end
   end

   assign status.is_load   = (itm_ff.mode == crd_pkg::MODE_LOAD);
   assign status.tick_on   = enabled_ff && itm_ff.time_ok;
   assign status.walk_go   = in_range && (limit != '0);
   assign status.walk_last = (idx_nx == limit);
   assign status.out_free  = !rsp_tvalid || rsp_tready;

   `CRD_ASSERT_IMPL(a_drop_queue_full, clock, reset, drop_ff != 4'd0, &pend_ff,
      "drop counted while a queue slot is free")
   `CRD_ASSERT_IMPL(a_walk_in_limit, clock, reset, cmd.walk_step, idx_ff < limit,
      "table walk past run count")
   `CRD_ASSERT_IMPL(a_publish_free, clock, reset, cmd.publish, status.out_free,
      "result overwrites an untaken word")
   `CRD_ASSERT_NEXT(a_stamp_set, clock, reset, cmd.tick_start, stamp_valid_ff,
      "minute stamp not valid after tick")

endmodule

`default_nettype wire

FILE: src/calendar_run_dispatcher.sv
// Calendar run dispatcher. Takes one request word at a time. A load writes a
// run table entry and clears the fired marks; a tick, when enabled and time is
// valid, dispatches the lowest pending queue slot unless a zone is busy, then
// walks the run table one entry per cycle through the table's single read port
// and enqueues runs matching the current weekday, hour and minute once per
// minute. A load steps through the setup, load and done states and an ignored
// tick through setup and done; an active tick steps through setup, tick, the
// walk over the first min(run_count, MAX_RUNS) entries when today lies within
// the date range, and done. The finished response sits in an output register,
// so the next word is taken while it waits; that next word finishes only once
// the waiting response has been taken. The table has no reset; entries in use
// must be loaded first. Depends on crd_pkg, crd_ctrl, crd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module calendar_run_dispatcher #(
   parameter int MAX_RUNS    = 8,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // entry_index, zone, day_mask, hour, minute, duration, time_ok, today,
   // weekday, year_day, zone_busy; zero pad
   input  wire  [95:0] req_tdata,
   // mode
   input  wire  [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // start_zone, start_duration, dropped; zero pad
   output logic [31:0] rsp_tdata,
   // start_valid
   output logic [0:0]  rsp_tuser,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   crd_pkg::item_type   item;
   crd_pkg::cmd_type    cmd;
   crd_pkg::status_type status;
   logic                start_valid;
   logic [7:0]          start_zone;
   logic [15:0]         start_duration;
   logic [3:0]          dropped;

   assign item.mode        = req_tuser[0];
   assign item.entry_index = req_tdata[2:0];
   assign item.zone        = req_tdata[10:3];
   assign item.day_mask    = req_tdata[17:11];
   assign item.hour        = req_tdata[22:18];
   assign item.minute      = req_tdata[28:23];
   assign item.duration    = req_tdata[44:29];
   assign item.time_ok     = req_tdata[45];
   assign item.today       = req_tdata[77:46];
   assign item.weekday     = req_tdata[80:78];
   assign item.year_day    = req_tdata[89:81];
   assign item.zone_busy   = req_tdata[90];

   crd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   crd_datapath #(
      .MAX_RUNS    (MAX_RUNS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .item           (item),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .start_valid    (start_valid),
      .start_zone     (start_zone),
      .start_duration (start_duration),
      .dropped        (dropped)
   );

   assign rsp_tuser = start_valid;
   assign rsp_tdata = {4'd0, dropped, start_duration, start_zone};

endmodule

`default_nettype wire
